// ===== hw/rtl/spq_pkg.sv =====
// Package for the stable priority queue: request, response, entry and
// cell control types with their codes. No dependencies.
package spq_pkg;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } spq_req_type_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } spq_status_t;

  typedef struct packed {
    spq_req_type_t      req_type;
    logic signed [31:0] item_value;
    logic [15:0]        item_prio;
  } spq_req_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    spq_status_t        status;
    logic [4:0]         occupancy;
  } spq_rsp_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [15:0]        rank;
  } spq_entry_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } spq_op_t;

  // Broadcast to every cell in the chain for one request.
  typedef struct packed {
    spq_op_t    op;
    spq_entry_t entry;
  } spq_ctrl_t;

endpackage

// ===== hw/rtl/spq_cell.sv =====
// One slot of the sorted chain: holds an entry and takes it from itself,
// the new request or a neighbour. Depends on spq_pkg.
module spq_cell
  import spq_pkg::*;
#(
  parameter int IDX    = 0,
  parameter int CountW = 5
) (
  input  logic              clk,
  input  spq_ctrl_t         ctrl,
  input  logic [CountW-1:0] count,
  input  spq_entry_t        left_entry,
  input  logic              left_after,
  input  spq_entry_t        right_entry,
  output spq_entry_t        entry,
  output logic              after
);

  logic occupied;

  // The slot holds a live entry when it lies below the fill count.
  assign occupied = count > CountW'(IDX);
  // A new request goes behind every entry of equal or smaller priority.
  assign after = occupied && (entry.rank <= ctrl.entry.rank);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_INSERT: begin
        if (!after) begin
          if (left_after) begin
            entry <= ctrl.entry;
          end else begin
            entry <= left_entry;
          end
        end
      end
      OP_REMOVE: begin
        entry <= right_entry;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/stable_priority_queue.sv =====
// Top level of the stable priority queue: a chain of spq_cell slots kept
// sorted by priority, a fill count and a response register. Depends on spq_pkg.
//
//   channel  valid      stall      payload    meaning
//   request  req_valid  req_stall  req_data   insert or remove
//   response rsp_valid  rsp_stall  rsp_data   head value, status, occupancy
//
// All cells compare against the new priority at once and shift on the same
// edge, so one request is taken per clock unless the response is stalled.
// The response appears in the register the cycle after the request.
// A request is taken whenever the response register is empty or is being
// emptied in the same cycle; a stalled response holds the request side.
// Reset clears the fill count and the response valid; the slots are not
// cleared, as only slots below the count are ever looked at.
module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  spq_req_t req_data,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output spq_rsp_t rsp_data
);

  localparam int CountW = $clog2(DEPTH + 1);

  logic [CountW-1:0] count;
  logic [CountW-1:0] count_next;
  logic              accept;
  logic              full;
  logic              empty;
  spq_ctrl_t         ctrl;
  spq_rsp_t          rsp_next;
  spq_entry_t        entries [DEPTH];
  logic              after   [DEPTH];

  // The request side is held only while a response waits to be taken.
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  assign full  = count == CountW'(DEPTH);
  assign empty = count == '0;

  // Decide what the chain does and what the response says. A remove from
  // an empty queue and an insert into a full one leave the chain and the count alone.
  always_comb begin
    ctrl.op          = OP_HOLD;
    ctrl.entry.value    = req_data.item_value;
    ctrl.entry.rank     = req_data.item_prio;
    count_next       = count;
    rsp_next.out_value = '0;
    rsp_next.status    = ST_OK;
    if (accept) begin
      if (req_data.req_type == REQ_INSERT) begin
        if (full) begin
          rsp_next.status = ST_OVERFLOW;
        end else begin
          ctrl.op    = OP_INSERT;
          count_next = count + 1'b1;
        end
      end else begin
        if (empty) begin
          rsp_next.status = ST_UNDERFLOW;
        end else begin
          ctrl.op            = OP_REMOVE;
          count_next         = count - 1'b1;
          rsp_next.out_value = entries[0].value;
        end
      end
    end
    rsp_next.occupancy = 5'(count_next);
  end

  // The chain itself. The first cell sees the new request as its left
  // neighbour; the last cell takes the request entry on a remove, which
  // is harmless as that slot drops out of the count.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_entry_t left_entry;
    spq_entry_t right_entry;
    logic       left_after;

    if (i == 0) begin : g_first
      assign left_entry = ctrl.entry;
      assign left_after = 1'b1;
    end else begin : g_inner
      assign left_entry = entries[i-1];
      assign left_after = after[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry = ctrl.entry;
    end else begin : g_mid
      assign right_entry = entries[i+1];
    end

    spq_cell #(
      .IDX    (i),
      .CountW (CountW)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .count       (count),
      .left_entry  (left_entry),
      .left_after  (left_after),
      .right_entry (right_entry),
      .entry       (entries[i]),
      .after       (after[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_data <= rsp_next;
    end
  end

  // The fill count never passes the number of slots.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(DEPTH))
    else $error("fill count beyond depth");

  // An overflow leaves the queue full and unchanged.
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    accept && req_data.req_type == REQ_INSERT && full |=> full)
    else $error("overflow changed the fill count");

  // A good remove shrinks the count by one and reports the old head.
  a_remove_head: assert property (@(posedge clk) disable iff (rst)
    accept && req_data.req_type == REQ_REMOVE && !empty
    |=> count == $past(count) - 1'b1 && rsp_data.out_value == $past(entries[0].value))
    else $error("remove did not take the head");

  // An underflow response carries a zero value and an empty queue.
  a_underflow_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status == ST_UNDERFLOW
    |-> rsp_data.out_value == '0 && rsp_data.occupancy == '0)
    else $error("underflow response not clean");

endmodule
